>>> src/sttl_pkg.sv
package sttl_pkg;

  localparam logic [1:0] MODE_BIND   = 2'd0;
  localparam logic [1:0] MODE_UNLOCK = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam int unsigned TTL_W = 31;
  localparam logic [TTL_W-1:0] TTL_DEFAULT = 31'd900000;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the input word
    logic append;      // append entry and respond
    logic scan_start;  // point scan at entry 0
    logic scan_next;   // advance scan
    logic hit_wb;      // update matched entry and respond
    logic miss;        // respond with failure
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] mode;
    logic       count_zero;
    logic       hit;
    logic       last;
  } stat_t;

endpackage

>>> src/sttl_ctrl.sv
module sttl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  sttl_pkg::stat_t stat_i,
  output sttl_pkg::cmd_t  cmd_o
);
  import sttl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.mode)
          MODE_BIND: begin
            cmd_o.append = 1'b1;
            state_d      = S_IDLE;
          end
          MODE_UNLOCK, MODE_QUERY: begin
            if (stat_i.count_zero) begin
              cmd_o.miss = 1'b1;
              state_d    = S_IDLE;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          default: begin
            cmd_o.miss = 1'b1;
            state_d    = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          state_d = S_WB;
        end else if (stat_i.last) begin
          cmd_o.miss = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_WB: begin
        cmd_o.hit_wb = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> src/sttl_dp.sv
module sttl_dp #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sttl_pkg::TTL_W-1:0]   cfg_ttl_ms_i,
  input  logic [1:0]                   mode_i,
  input  logic [63:0]                  session_tag_i,
  input  logic [63:0]                  now_ms_i,
  input  sttl_pkg::cmd_t               cmd_i,
  output sttl_pkg::stat_t              stat_o,
  output logic                         done_o,
  output logic                         status_o,
  output logic                         unlocked_o,
  output logic [5:0]                   entry_count_o
);
  import sttl_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [TTL_W-1:0] ttl_q;
  logic [1:0]       mode_q;
  logic [63:0]      tag_q, now_q;
  logic [CW-1:0]    count_q;
  logic [AW-1:0]    scan_q, scan_d;
  logic             done_q, status_q, unl_q;

  logic [63:0] tag_mem [ENTRIES];
  logic        lock_mem [ENTRIES];
  logic [63:0] dl_mem [ENTRIES];
  logic [63:0] tag_rd_q, dl_rd_q;
  logic        lock_rd_q;

  logic          full, bind_wr, relock, lock_we, lock_wdata, dl_we;
  logic [AW-1:0] lock_addr;
  logic [63:0]   deadline;

  assign full     = (count_q == CW'(ENTRIES));
  assign bind_wr  = cmd_i.append && !full;
  assign relock   = !lock_rd_q && (now_q >= dl_rd_q);
  assign deadline = now_q + {33'd0, ttl_q};

  always_comb begin
    scan_d = scan_q;
    if (cmd_i.scan_start) begin
      scan_d = '0;
    end else if (cmd_i.scan_next) begin
      scan_d = scan_q + AW'(1);
    end
  end

  always_comb begin
    lock_we    = 1'b0;
    lock_wdata = 1'b1;
    lock_addr  = scan_q;
    dl_we      = 1'b0;
    if (bind_wr) begin
      lock_we   = 1'b1;
      lock_addr = count_q[AW-1:0];
    end else if (cmd_i.hit_wb) begin
      if (mode_q == MODE_UNLOCK) begin
        lock_we    = 1'b1;
        lock_wdata = 1'b0;
        dl_we      = 1'b1;
      end else begin
        lock_we = relock;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bind_wr) begin
      tag_mem[count_q[AW-1:0]] <= tag_q;
    end
    tag_rd_q <= tag_mem[scan_d];
  end

  always_ff @(posedge clk_i) begin
    if (lock_we) begin
      lock_mem[lock_addr] <= lock_wdata;
    end
    lock_rd_q <= lock_mem[scan_d];
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_mem[scan_q] <= deadline;
    end
    dl_rd_q <= dl_mem[scan_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      tag_q  <= session_tag_i;
      now_q  <= now_ms_i;
    end
    if (cmd_i.append) begin
      status_q <= full;
      unl_q    <= 1'b0;
    end else if (cmd_i.miss) begin
      status_q <= 1'b1;
      unl_q    <= 1'b0;
    end else if (cmd_i.hit_wb) begin
      status_q <= 1'b0;
      unl_q    <= (mode_q == MODE_QUERY) && !lock_rd_q && !relock;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q   <= TTL_DEFAULT;
      count_q <= '0;
      scan_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ttl_q <= (cfg_ttl_ms_i == '0) ? TTL_DEFAULT : cfg_ttl_ms_i;
      end
      if (bind_wr) begin
        count_q <= count_q + CW'(1);
      end
      scan_q <= scan_d;
      done_q <= cmd_i.append || cmd_i.miss || cmd_i.hit_wb;
    end
  end

  assign stat_o.mode       = mode_q;
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.hit        = (tag_rd_q == tag_q);
  assign stat_o.last       = ((CW'(scan_q) + CW'(1)) == count_q);

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign unlocked_o    = unl_q;
  assign entry_count_o = 6'(count_q);

endmodule

>>> src/session_ttl_unlock_table.sv
// Flow: bind, unused mode or empty table respond straight from the exec state; unlock/query
// scan one entry per cycle through the tag memory read port, then write back on a hit or
// respond with failure after the last entry.
// One word at a time: start is taken while busy is low.
// done_o strobes one cycle with the result; the receiver cannot stall it.
// Reset clears the entry count and sets ttl to 900000; table memories are not cleared.
module session_ttl_unlock_table #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_ttl_ms_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [63:0] session_tag_i,
  input  logic [63:0] now_ms_i,
  output logic        done_o,
  output logic        status_o,
  output logic        unlocked_o,
  output logic [5:0]  entry_count_o
);
  import sttl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sttl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sttl_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_ttl_ms_i  (cfg_ttl_ms_i),
    .mode_i        (mode_i),
    .session_tag_i (session_tag_i),
    .now_ms_i      (now_ms_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .unlocked_o    (unlocked_o),
    .entry_count_o (entry_count_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result strobe outside end of operation");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (start && !busy))
    else $error("word captured while busy");

endmodule

>>> tb/tb_session_ttl_unlock_table.sv
`timescale 1ns / 1ps
module tb_session_ttl_unlock_table;
  import sttl_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic ST_OK = 1'b0;
  localparam logic ST_FAIL = 1'b1;
  localparam logic [63:0] ONES = '1;
  localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] tag;
    logic [63:0] now;
  } word_t;

  typedef struct packed {
    logic       status;
    logic       unlocked;
    logic [5:0] count;
  } answer_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [30:0] cfg_ttl_ms_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode_i = '0;
  logic [63:0] session_tag_i = '0;
  logic [63:0] now_ms_i = '0;
  logic        done_o;
  logic        status_o;
  logic        unlocked_o;
  logic [5:0]  entry_count_o;

  session_ttl_unlock_table #(.ENTRIES(DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_ttl_ms_i  (cfg_ttl_ms_i),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .session_tag_i (session_tag_i),
    .now_ms_i      (now_ms_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .unlocked_o    (unlocked_o),
    .entry_count_o (entry_count_o)
  );

  // shadow of the binding table
  logic [63:0] bound_tag [DEPTH];
  bit          locked_now [DEPTH];
  logic [63:0] unlock_deadline [DEPTH];
  int unsigned bound_count = 0;
  logic [30:0] ttl_cur = TTL_DEFAULT;

  word_t   pending_words[$];
  answer_t answers_due[$];
  word_t   next_word;
  answer_t due;
  bit      took = 1'b0;
  bit      steady = 1'b0;
  int      faults = 0;
  logic [63:0] wall_ms = '0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int find_binding(logic [63:0] tag);
    for (int i = 0; i < int'(bound_count); i++) begin
      if (bound_tag[i] == tag) return i;
    end
    return -1;
  endfunction

  function automatic answer_t table_apply(word_t w);
    answer_t a;
    int k;
    a.status = ST_FAIL;
    a.unlocked = 1'b0;
    k = find_binding(w.tag);
    case (w.mode)
      MODE_BIND: begin
        if (bound_count < DEPTH) begin
          bound_tag[bound_count] = w.tag;
          locked_now[bound_count] = 1'b1;
          bound_count++;
          a.status = ST_OK;
        end
      end
      MODE_UNLOCK: begin
        if (k >= 0) begin
          locked_now[k] = 1'b0;
          unlock_deadline[k] = w.now + {33'd0, ttl_cur};
          a.status = ST_OK;
        end
      end
      MODE_QUERY: begin
        if (k >= 0) begin
          if (!locked_now[k] && w.now >= unlock_deadline[k]) locked_now[k] = 1'b1;
          a.unlocked = !locked_now[k];
          a.status = ST_OK;
        end
      end
      default: ;
    endcase
    a.count = bound_count[5:0];
    return a;
  endfunction

  function automatic logic [63:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  // driver: new word at the falling edge once the previous one was taken
  always @(negedge clk_i) begin
    if (!start || took) begin
      if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
        next_word = pending_words.pop_front();
        start <= 1'b1;
        mode_i <= next_word.mode;
        session_tag_i <= next_word.tag;
        now_ms_i <= next_word.now;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, predict on acceptance
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      if (answers_due.size() == 0) begin
        $error("result word with no expectation waiting");
        faults++;
      end else begin
        due = answers_due.pop_front();
        if (status_o !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, status_o);
          faults++;
        end
        if (unlocked_o !== due.unlocked) begin
          $error("unlocked: expected %0d, got %0d", due.unlocked, unlocked_o);
          faults++;
        end
        if (entry_count_o !== due.count) begin
          $error("entry_count: expected %0d, got %0d", due.count, entry_count_o);
          faults++;
        end
      end
    end
    if (rst_ni && start && !busy)
      answers_due.push_back(table_apply(word_t'{mode_i, session_tag_i, now_ms_i}));
    took <= rst_ni && start && !busy;
  end

  task automatic queue_word(word_t w);
    while (pending_words.size() != 0) @(posedge clk_i);
    pending_words.push_back(w);
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || start || busy || answers_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_ttl(logic [30:0] v);
    settle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_ttl_ms_i <= v;
    ttl_cur = (v == '0) ? TTL_DEFAULT : v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_words(int n);
    word_t w;
    int pick;
    int k;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      w.mode = (pick < 12) ? MODE_BIND : (pick < 45) ? MODE_UNLOCK :
               (pick < 93) ? MODE_QUERY : MODE_NONE;
      w.tag = wide_random();
      if (bound_count != 0 && $urandom_range(99) < ((w.mode == MODE_BIND) ? 15 : 85))
        w.tag = bound_tag[$urandom_range(bound_count - 1)];
      else if ($urandom_range(9) == 0)
        w.tag = $urandom_range(1) ? ONES : '0;
      pick = $urandom_range(9);
      if (pick < 5)
        wall_ms += 64'($urandom_range(3));
      else if (pick < 7)
        wall_ms += 64'($urandom_range(ttl_cur / 2));
      else if (pick == 7)
        wall_ms += {33'd0, ttl_cur} + 64'($urandom_range(3));
      else if (pick == 8)
        wall_ms = ONES - 64'($urandom_range(ttl_cur));
      else
        wall_ms -= 64'($urandom_range(ttl_cur));
      w.now = wall_ms;
      k = find_binding(w.tag);
      // land on either side of the deadline
      if (w.mode == MODE_QUERY && k >= 0 && !locked_now[k] && $urandom_range(99) < 40)
        w.now = unlock_deadline[k] + 64'($urandom_range(4)) - 64'd2;
      else if ($urandom_range(99) < 4)
        w.now = wide_random();
      queue_word(w);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table
    queue_word(word_t'{MODE_QUERY, 64'd0, 64'd0});
    queue_word(word_t'{MODE_UNLOCK, 64'd0, 64'd0});
    queue_word(word_t'{MODE_NONE, 64'd0, 64'd0});
    // binds, duplicate tag
    queue_word(word_t'{MODE_BIND, 64'd0, ONES});
    queue_word(word_t'{MODE_BIND, ONES, 64'd0});
    queue_word(word_t'{MODE_BIND, 64'd0, 64'd7});
    queue_word(word_t'{MODE_QUERY, 64'd0, 64'd0});
    // deadline wraps past 2^64
    queue_word(word_t'{MODE_UNLOCK, ONES, ONES});
    queue_word(word_t'{MODE_QUERY, ONES, ONES});
    queue_word(word_t'{MODE_QUERY, ONES, 64'd0});
    // just before and at the deadline
    queue_word(word_t'{MODE_UNLOCK, 64'd0, 64'd1000});
    queue_word(word_t'{MODE_QUERY, 64'd0, 64'd900999});
    queue_word(word_t'{MODE_QUERY, 64'd0, 64'd901000});
    queue_word(word_t'{MODE_QUERY, 64'd0, 64'd0});
    queue_word(word_t'{MODE_UNLOCK, 64'd0, 64'd5});
    queue_word(word_t'{MODE_QUERY, 64'd0, 64'd5});
    // unmatched tags, unused mode on a populated table
    queue_word(word_t'{MODE_QUERY, 64'h5A5A_5A5A_A5A5_A5A5, 64'd5});
    queue_word(word_t'{MODE_UNLOCK, TOP_BIT, 64'd5});
    queue_word(word_t'{MODE_NONE, ONES, ONES});
    queue_word(word_t'{MODE_BIND, TOP_BIT, 64'd0});
    queue_word(word_t'{MODE_UNLOCK, TOP_BIT, 64'hAAAA_AAAA_AAAA_AAAA});
    queue_word(word_t'{MODE_QUERY, TOP_BIT, 64'h5555_5555_5555_5555});
    queue_word(word_t'{MODE_QUERY, TOP_BIT, ONES});

    write_ttl(31'd1);
    random_words(300);
    write_ttl(31'h7FFF_FFFF);
    steady = 1'b1;
    random_words(150);
    steady = 1'b0;
    random_words(160);
    write_ttl(31'd0);
    random_words(310);
    write_ttl(31'($urandom_range(1000, 1)));
    random_words(310);
    write_ttl(31'($urandom));
    random_words(310);

    settle();
    repeat (40) @(posedge clk_i);
    if (faults == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
